/* sv/pipw_pkg.sv */
// package for the point-in-polygon winding block
// shared widths, request and result types, controller commands and the cordic table
// no dependencies
`timescale 1ns / 1ps

package pipw_pkg;

    // coordinate format, signed q16.8
    localparam int COORD_WIDTH = 24;
    localparam int EXACT_LIMIT = 29;
    localparam int DIFF_SHIFT = (COORD_WIDTH > EXACT_LIMIT) ? COORD_WIDTH - EXACT_LIMIT : 0;
    localparam int DIFF_WIDTH = ((COORD_WIDTH > EXACT_LIMIT) ? EXACT_LIMIT : COORD_WIDTH) + 1;
    localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
    localparam int CROSS_WIDTH = PROD_WIDTH + 1;
    localparam int CORDIC_WIDTH = PROD_WIDTH + 3;
    localparam int CORDIC_STEPS = 24;
    localparam int ANGLE_WIDTH = 27;
    localparam int SUM_WIDTH = 40;
    localparam int THR_WIDTH = 25;
    localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1678);
    localparam logic signed [ANGLE_WIDTH-1:0] HALF_PI = ANGLE_WIDTH'(8388608);
    localparam int MAX_VERTICES_DEF = 1024;

    // operation codes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef struct packed {
        logic                          op;
        logic signed [COORD_WIDTH-1:0] coord_x;
        logic signed [COORD_WIDTH-1:0] coord_y;
        logic                          restart;
    } pipw_req_t;

    typedef struct packed {
        logic                         inside_res;
        logic signed [SUM_WIDTH-1:0]  angle_sum;
    } pipw_res_t;

    // controller to datapath
    typedef struct packed {
        logic wr_en;
        logic latch_q;
        logic clr_acc;
        logic rd_en;
        logic rd_edge;
    } pipw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pipe_empty;
    } pipw_sts_t;

    // vertex minus query, scaled down for wide coordinates
    function automatic logic signed [DIFF_WIDTH-1:0] coord_diff(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        logic signed [COORD_WIDTH:0] full;
        logic signed [COORD_WIDTH:0] shifted;
        begin
            full = (COORD_WIDTH+1)'(a) - (COORD_WIDTH+1)'(b);
            shifted = full >>> DIFF_SHIFT;
            return shifted[DIFF_WIDTH-1:0];
        end
    endfunction

    // atan(2^-i) in units where pi is 2^24
    function automatic logic [22:0] atan_unit(input int i);
        logic [22:0] t;
        begin
            case (i)
                0:  t = 23'd4194304;
                1:  t = 23'd2476042;
                2:  t = 23'd1308273;
                3:  t = 23'd664100;
                4:  t = 23'd333339;
                5:  t = 23'd166832;
                6:  t = 23'd83436;
                7:  t = 23'd41721;
                8:  t = 23'd20861;
                9:  t = 23'd10430;
                10: t = 23'd5215;
                11: t = 23'd2608;
                12: t = 23'd1304;
                13: t = 23'd652;
                14: t = 23'd326;
                15: t = 23'd163;
                16: t = 23'd81;
                17: t = 23'd41;
                18: t = 23'd20;
                19: t = 23'd10;
                20: t = 23'd5;
                21: t = 23'd3;
                22: t = 23'd1;
                23: t = 23'd1;
                default: t = 23'd0;
            endcase
            return t;
        end
    endfunction

endpackage

/* sv/point_in_polygon_winding.sv */
// top level of the point-in-polygon winding block
// depends on pipw_pkg, pipw_ctrl, pipw_dp
//
// usage:
//   a request is taken at a rising edge with start high and busy low.
//   req.op append stores one vertex and busy stays low;
//   req.restart empties the polygon first. appends past capacity are dropped.
//   req.op test walks every stored edge of the polygon against the query
//   point and sums the edge angles through a 24-stage cordic pipeline.
//   a test of an n-vertex polygon keeps busy high while it reads the vertex
//   ram, one read per cycle for n + 1 reads, then while the product and
//   cordic pipeline drains, and through the report state; the vertex ram read
//   port sets the rate.
//   the result sits on res for exactly one cycle with done high; the
//   receiver cannot stall it, so it must take it in that cycle.
//   cfg_we writes the inside threshold (pi is 2^24 units) at any edge;
//   write it only while the block is idle.
//   reset clears the vertex count and loads the default threshold; the
//   vertex ram itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module point_in_polygon_winding
    import pipw_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  pipw_req_t            req,
    output logic                 busy,
    output logic                 done,
    output pipw_res_t            res,
    input  logic                 cfg_we,
    input  logic [THR_WIDTH-1:0] cfg_wdata
);

    localparam int IW = $clog2(MAX_VERTICES);

    pipw_cmd_t cmd;
    pipw_sts_t sts;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_addr;

    // sequencing
    pipw_ctrl #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .req(req),
        .busy(busy),
        .done(done),
        .cmd(cmd),
        .wr_addr(wr_addr),
        .rd_addr(rd_addr),
        .sts(sts)
    );

    // storage and arithmetic
    pipw_dp #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .wr_addr(wr_addr),
        .rd_addr(rd_addr),
        .req(req),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .sts(sts),
        .res(res)
    );

endmodule

/* sv/pipw_ram.sv */
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pipw_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/pipw_ctrl.sv */
// controller for the winding block: vertex count, edge walk and report sequencing
// depends on pipw_pkg
`timescale 1ns / 1ps

module pipw_ctrl
    import pipw_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  pipw_req_t                       req,
    output logic                            busy,
    output logic                            done,
    output pipw_cmd_t                       cmd,
    output logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
    output logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    input  pipw_sts_t                       sts
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_REPORT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic accept;

    assign accept = start && (state_reg == ST_IDLE);

    // state, walk index and vertex count
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        cmd = '0;
        wr_addr = cnt_reg[IW-1:0];
        rd_addr = (idx_reg == cnt_reg) ? '0 : idx_reg[IW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.op == OP_APPEND)
                begin
                    if (req.restart)
                    begin
                        cmd.wr_en = 1'b1;
                        wr_addr = '0;
                        cnt_next = CW'(1);
                    end
                    else if (cnt_reg < MAX_CNT)
                    begin
                        cmd.wr_en = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
                else if (accept)
                begin
                    cmd.latch_q = 1'b1;
                    cmd.clr_acc = 1'b1;
                    idx_next = '0;
                    state_next = (cnt_reg == '0) ? ST_REPORT : ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_edge = (idx_reg != '0);
                idx_next = idx_reg + CW'(1);
                if (idx_reg == cnt_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.pipe_empty)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_REPORT);

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT) else $error("vertex count above capacity");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> idx_reg <= cnt_reg) else $error("walk index past count");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");
    a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.op == OP_TEST |=> busy) else $error("test request did not raise busy");

endmodule

/* sv/pipw_dp.sv */
// datapath for the winding block: vertex ram, cross/dot products, cordic pipe, angle sum
// depends on pipw_pkg and pipw_ram
`timescale 1ns / 1ps

module pipw_dp
    import pipw_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pipw_cmd_t                       cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
    input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    input  pipw_req_t                       req,
    input  logic                            cfg_we,
    input  logic [THR_WIDTH-1:0]            cfg_wdata,
    output pipw_sts_t                       sts,
    output pipw_res_t                       res
);

    localparam int XW = CORDIC_WIDTH;
    localparam int ZW = ANGLE_WIDTH;
    localparam int DW = DIFF_WIDTH;
    localparam int SW0 = $clog2(MAX_VERTICES + 1) + ZW + 1;
    localparam int SW = (SW0 > SUM_WIDTH + 1) ? SW0 : SUM_WIDTH + 1;
    localparam logic signed [SW-1:0] SUM_HI = SW'(40'sh7F_FFFF_FFFF);
    localparam logic signed [SW-1:0] SUM_LO = SW'(40'sh80_0000_0000);

    logic [THR_WIDTH-1:0] thr_reg;
    logic signed [COORD_WIDTH-1:0] qx_reg, qy_reg;
    logic [2*COORD_WIDTH-1:0] rdata;
    logic signed [COORD_WIDTH-1:0] vx_cur, vy_cur;
    logic signed [DW-1:0] dx_cur, dy_cur;
    logic rv_reg, re_reg;
    logic signed [DW-1:0] pdx_reg, pdy_reg;
    logic sd_v_reg;
    logic signed [DW-1:0] ux_reg, uy_reg, wx_reg, wy_reg;
    logic sm_v_reg;
    logic signed [PROD_WIDTH-1:0] p_uxwy_reg, p_uywx_reg, p_uxwx_reg, p_uywy_reg;
    logic sc_v_reg;
    logic signed [CROSS_WIDTH-1:0] cr_reg, dt_reg;
    logic signed [XW-1:0] cr_x, dt_x;
    logic signed [XW-1:0] cx_reg [0:CORDIC_STEPS];
    logic signed [XW-1:0] cy_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] cz_reg [0:CORDIC_STEPS];
    logic cnz_reg [0:CORDIC_STEPS];
    logic cv_reg [0:CORDIC_STEPS];
    logic signed [SW-1:0] acc_reg;
    logic signed [SW-1:0] mag;
    logic signed [SW-1:0] sat;
    logic busy_pipe;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // query point
    always_ff @(posedge clk)
    begin
        if (cmd.latch_q)
        begin
            qx_reg <= req.coord_x;
            qy_reg <= req.coord_y;
        end
    end

    // vertex store, x in the upper half
    pipw_ram #(
        .WIDTH(2 * COORD_WIDTH),
        .DEPTH(MAX_VERTICES)
    ) u_ram (
        .clk(clk),
        .we(cmd.wr_en),
        .waddr(wr_addr),
        .wdata({req.coord_x, req.coord_y}),
        .re(cmd.rd_en),
        .raddr(rd_addr),
        .rdata(rdata)
    );

    assign vx_cur = rdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign vy_cur = rdata[COORD_WIDTH-1:0];
    assign dx_cur = coord_diff(vx_cur, qx_reg);
    assign dy_cur = coord_diff(vy_cur, qy_reg);

    // operand stages: differences, products, cross and dot
    always_ff @(posedge clk)
    begin
        if (rv_reg)
        begin
            pdx_reg <= dx_cur;
            pdy_reg <= dy_cur;
        end
        ux_reg <= pdx_reg;
        uy_reg <= pdy_reg;
        wx_reg <= dx_cur;
        wy_reg <= dy_cur;
        p_uxwy_reg <= PROD_WIDTH'(ux_reg) * PROD_WIDTH'(wy_reg);
        p_uywx_reg <= PROD_WIDTH'(uy_reg) * PROD_WIDTH'(wx_reg);
        p_uxwx_reg <= PROD_WIDTH'(ux_reg) * PROD_WIDTH'(wx_reg);
        p_uywy_reg <= PROD_WIDTH'(uy_reg) * PROD_WIDTH'(wy_reg);
        cr_reg <= CROSS_WIDTH'(p_uxwy_reg) - CROSS_WIDTH'(p_uywx_reg);
        dt_reg <= CROSS_WIDTH'(p_uxwx_reg) + CROSS_WIDTH'(p_uywy_reg);
    end

    assign cr_x = XW'(cr_reg);
    assign dt_x = XW'(dt_reg);

    // pre-rotation into the right half plane
    always_ff @(posedge clk)
    begin
        cnz_reg[0] <= (cr_reg == '0) && (dt_reg == '0);
        if (dt_reg < 0 && cr_reg >= 0)
        begin
            cx_reg[0] <= cr_x;
            cy_reg[0] <= -dt_x;
            cz_reg[0] <= HALF_PI;
        end
        else if (dt_reg < 0)
        begin
            cx_reg[0] <= -cr_x;
            cy_reg[0] <= dt_x;
            cz_reg[0] <= -HALF_PI;
        end
        else
        begin
            cx_reg[0] <= dt_x;
            cy_reg[0] <= cr_x;
            cz_reg[0] <= '0;
        end
    end

    // cordic vectoring stages, one micro-rotation each
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            cnz_reg[i+1] <= cnz_reg[i];
            if (cy_reg[i] >= 0)
            begin
                cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                cz_reg[i+1] <= cz_reg[i] + ZW'(atan_unit(i));
            end
            else
            begin
                cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                cz_reg[i+1] <= cz_reg[i] - ZW'(atan_unit(i));
            end
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
            re_reg <= 1'b0;
            sd_v_reg <= 1'b0;
            sm_v_reg <= 1'b0;
            sc_v_reg <= 1'b0;
            for (int i = 0; i <= CORDIC_STEPS; i++)
            begin
                cv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            rv_reg <= cmd.rd_en;
            re_reg <= cmd.rd_edge;
            sd_v_reg <= rv_reg && re_reg;
            sm_v_reg <= sd_v_reg;
            sc_v_reg <= sm_v_reg;
            cv_reg[0] <= sc_v_reg;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end
    end

    // angle accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.clr_acc)
        begin
            acc_reg <= '0;
        end
        else if (cv_reg[CORDIC_STEPS] && !cnz_reg[CORDIC_STEPS])
        begin
            acc_reg <= acc_reg + SW'(cz_reg[CORDIC_STEPS]);
        end
    end

    // pipeline occupancy
    always_comb
    begin
        busy_pipe = rv_reg || sd_v_reg || sm_v_reg || sc_v_reg;
        for (int i = 0; i <= CORDIC_STEPS; i++)
        begin
            busy_pipe = busy_pipe || cv_reg[i];
        end
    end

    assign sts.pipe_empty = !busy_pipe;

    // result: threshold test on the full sum, saturated output
    assign mag = (acc_reg < 0) ? -acc_reg : acc_reg;
    assign sat = (acc_reg > SUM_HI) ? SUM_HI : ((acc_reg < SUM_LO) ? SUM_LO : acc_reg);
    assign res.inside_res = (mag > SW'(thr_reg));
    assign res.angle_sum = sat[SUM_WIDTH-1:0];

endmodule

/* tb/point_in_polygon_winding_test.sv */
// testbench for the point-in-polygon winding block: directed and random vertex/query requests
// a scoreboard class predicts each winding angle sum and checks every result in order
// depends on pipw_pkg and point_in_polygon_winding
`timescale 1ns / 1ps

module point_in_polygon_winding_test;
    import pipw_pkg::*;

    localparam int NVERT = 1024;
    localparam int WATCHDOG_LIMIT = 20000;

    // winding predictor and queue of expected sums
    class winding_scoreboard;
        logic signed [COORD_WIDTH-1:0] vx[NVERT];
        logic signed [COORD_WIDTH-1:0] vy[NVERT];
        int unsigned nvert;
        logic [THR_WIDTH-1:0] threshold;
        pipw_res_t sums_pending[$];
        int mismatches;

        function void clear_state();
            nvert = 0;
            threshold = THR_RESET;
        endfunction

        function longint shr(longint v, int s);
            return v >>> s;
        endfunction

        function longint atan_tab(int i);
            longint t[24] = '{4194304, 2476042, 1308273, 664100, 333339, 166832, 83436,
                41721, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
                5, 3, 1, 1};
            return t[i];
        endfunction

        function longint edge_turn(longint c, longint d);
            longint x, y, z, nx, ny;
            if (c == 0 && d == 0)
                return 0;
            if (d < 0)
            begin
                if (c >= 0)
                begin
                    x = c; y = -d; z = 8388608;
                end
                else
                begin
                    x = -c; y = d; z = -8388608;
                end
            end
            else
            begin
                x = d; y = c; z = 0;
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                if (y >= 0)
                begin
                    nx = x + shr(y, i); ny = y - shr(x, i); z += atan_tab(i);
                end
                else
                begin
                    nx = x - shr(y, i); ny = y + shr(x, i); z -= atan_tab(i);
                end
                x = nx; y = ny;
            end
            return z;
        endfunction

        // note an accepted request
        function void note_request(pipw_req_t r);
            longint sum, mag, qx, qy, ux, uy, wx, wy;
            int unsigned j;
            pipw_res_t e;
            if (r.op == OP_APPEND)
            begin
                if (r.restart)
                    nvert = 0;
                if (nvert < NVERT)
                begin
                    vx[nvert] = r.coord_x;
                    vy[nvert] = r.coord_y;
                    nvert++;
                end
                return;
            end
            qx = r.coord_x;
            qy = r.coord_y;
            sum = 0;
            for (int unsigned i = 0; i < nvert; i++)
            begin
                j = (i + 1 < nvert) ? i + 1 : 0;
                ux = longint'(vx[i]) - qx; uy = longint'(vy[i]) - qy;
                wx = longint'(vx[j]) - qx; wy = longint'(vy[j]) - qy;
                sum += edge_turn(ux * wy - uy * wx, ux * wx + uy * wy);
            end
            mag = (sum < 0) ? -sum : sum;
            e.inside_res = (mag > longint'(threshold));
            if (sum > 64'sd549755813887)
                e.angle_sum = 40'sh7f_ffff_ffff;
            else if (sum < -64'sd549755813888)
                e.angle_sum = 40'sh80_0000_0000;
            else
                e.angle_sum = sum[SUM_WIDTH-1:0];
            sums_pending = {sums_pending, e};
        endfunction

        // check one result against the oldest expected sum
        function void check_result(pipw_res_t got);
            pipw_res_t e;
            if (sums_pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result inside=%0d sum=%0d", got.inside_res,
                        got.angle_sum);
                return;
            end
            e = sums_pending.pop_front();
            if (got.inside_res !== e.inside_res || got.angle_sum !== e.angle_sum)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected inside=%0d sum=%0d, got inside=%0d sum=%0d",
                        e.inside_res, e.angle_sum, got.inside_res, got.angle_sum);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    pipw_req_t req;
    logic busy;
    logic done;
    pipw_res_t res;
    logic cfg_we;
    logic [THR_WIDTH-1:0] cfg_wdata;

    winding_scoreboard board;
    int idle_cycles;
    int tests_sent;

    point_in_polygon_winding u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req), .busy(busy),
        .done(done), .res(res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // result sampling and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_result(res);
            if ((start && !busy) || done || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG_LIMIT)
            begin
                $display("point_in_polygon_winding regression: fail");
                $finish;
            end
        end
    end

    // random gap, mostly short, sometimes long
    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 3) == 0)
            n = 0;
        else if ($urandom_range(0, 15) == 0)
            n = $urandom_range(10, 60);
        else
            n = $urandom_range(0, 3);
        repeat (n) @(negedge clk);
    endtask

    // issue one request and wait until it is taken
    task automatic send_request(logic op, logic signed [COORD_WIDTH-1:0] x,
                                logic signed [COORD_WIDTH-1:0] y, logic rs);
        req.op = op;
        req.coord_x = x;
        req.coord_y = y;
        req.restart = rs;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(req);
        if (op == OP_TEST)
            tests_sent++;
        @(negedge clk);
        start = 1'b0;
        idle_gap();
    endtask

    // write the threshold once the block has drained
    task automatic write_threshold(logic [THR_WIDTH-1:0] v);
        while (board.sums_pending.size() != 0 || busy)
            @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        board.threshold = v;
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] rand_coord(int mode);
        case (mode)
            0: return COORD_WIDTH'($urandom);
            1: return COORD_WIDTH'($signed($urandom_range(0, 8000)) - 4000);
            default: return COORD_WIDTH'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    // one random polygon built then queried
    task automatic random_polygon(int nv);
        int mode;
        int r;
        longint a;
        mode = $urandom_range(0, 2);
        r = (mode == 0) ? 4000000 : ((mode == 1) ? 3000 : 800000);
        for (int i = 0; i < nv; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_request(OP_APPEND, rand_coord(mode), rand_coord(mode), i == 0);
            else
            begin
                a = i * 6283 / nv;
                send_request(OP_APPEND,
                    COORD_WIDTH'(longint'($floor(r * $cos(a / 1000.0)))),
                    COORD_WIDTH'(longint'($floor(r * $sin(a / 1000.0)))), i == 0);
            end
        end
        repeat ($urandom_range(1, 5))
        begin
            if ($urandom_range(0, 9) == 0)
                send_request(OP_APPEND, rand_coord(0), rand_coord(0), 1'($urandom));
            else
                send_request(OP_TEST, rand_coord(mode == 0 ? 0 : 1) >>> $urandom_range(0, 4),
                    rand_coord(1), 1'($urandom));
        end
    endtask

    initial
    begin
        int items;
        board = new();
        board.clear_state();
        board.mismatches = 0;
        idle_cycles = 0;
        tests_sent = 0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty and single-vertex polygons, then a square with edge cases
        send_request(OP_TEST, 24'sd0, 24'sd0, 1'b1);
        send_request(OP_APPEND, 24'sh7fffff, 24'sh800000, 1'b1);
        send_request(OP_TEST, 24'sd0, 24'sd0, 1'b0);
        send_request(OP_APPEND, 24'sh800000, 24'sh800000, 1'b1);
        send_request(OP_APPEND, 24'sh7fffff, 24'sh800000, 1'b0);
        send_request(OP_APPEND, 24'sh7fffff, 24'sh7fffff, 1'b0);
        send_request(OP_APPEND, 24'sh800000, 24'sh7fffff, 1'b0);
        send_request(OP_TEST, 24'sd0, 24'sd0, 1'b1);
        send_request(OP_TEST, 24'sh7fffff, 24'sh7fffff, 1'b0);
        send_request(OP_TEST, 24'sd0, 24'sh800000, 1'b0);
        send_request(OP_TEST, 24'sh800000, 24'sd0, 1'b0);
        send_request(OP_TEST, 24'sh7fffff, 24'sh800000, 1'b0);
        write_threshold(25'd16777216);
        send_request(OP_TEST, 24'sd100, 24'sd100, 1'b0);
        write_threshold(25'd0);
        send_request(OP_TEST, 24'sd100, 24'sd100, 1'b0);
        send_request(OP_TEST, 24'sh7fffff, 24'sd0, 1'b0);
        write_threshold(THR_RESET);

        // random polygons, mostly small
        items = 0;
        while (items < 560)
        begin
            int nv;
            nv = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 64) : $urandom_range(0, 8);
            if ($urandom_range(0, 11) == 0)
                write_threshold($urandom_range(0, 3) == 0 ? 25'd16777216
                    : 25'($urandom_range(0, 33554431)));
            random_polygon(nv);
            items += nv + 3;
        end

        while (board.sums_pending.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (board.mismatches == 0)
            $display("point_in_polygon_winding regression: pass");
        else
            $display("point_in_polygon_winding regression: fail");
        $finish;
    end

endmodule
